// ===== rtl/core/particle_cube_binning_sort_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Particle cube binning sort assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_CUBE_BINNING_SORT_UNIT_MACROS_SVH
`define PARTICLE_CUBE_BINNING_SORT_UNIT_MACROS_SVH

// Check cons in the same cycle as ante
`define PCBS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante
`define PCBS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/pcbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Particle cube binning sort package
// Sizes, codes, payload structs and sequencer states of the binning sort.
// ----------------------------------------------------------------------------
package pcbs_pkg;

   localparam int MAX_PARTICLES = 4096;
   localparam int MAX_CUBES     = 4096;
   localparam int PART_AW       = $clog2(MAX_PARTICLES);
   localparam int CUBE_AW       = $clog2(MAX_CUBES);
   localparam int COUNT_W       = 13;

   // operation codes
   localparam logic [2:0] OP_LOAD     = 3'd0;
   localparam logic [2:0] OP_FINALIZE = 3'd1;
   localparam logic [2:0] OP_RANGE    = 3'd2;
   localparam logic [2:0] OP_SLOT     = 3'd3;
   localparam logic [2:0] OP_CLEAR    = 3'd4;

   // status codes
   localparam logic [2:0] STAT_OK      = 3'd0;
   localparam logic [2:0] STAT_OUTSIDE = 3'd1;
   localparam logic [2:0] STAT_FULL    = 3'd2;
   localparam logic [2:0] STAT_NOTFIN  = 3'd3;
   localparam logic [2:0] STAT_BAD     = 3'd4;

   // register indexes
   localparam logic [2:0] CSR_MIN_X   = 3'd0;
   localparam logic [2:0] CSR_MIN_Y   = 3'd1;
   localparam logic [2:0] CSR_MIN_Z   = 3'd2;
   localparam logic [2:0] CSR_INV     = 3'd3;
   localparam logic [2:0] CSR_CUBES_X = 3'd4;
   localparam logic [2:0] CSR_CUBES_Y = 3'd5;
   localparam logic [2:0] CSR_CUBES_Z = 3'd6;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [11:0]        query_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [11:0] cube_id;
      logic [12:0] range_first;
      logic [12:0] range_last;
      logic [11:0] sorted_slot;
      logic [11:0] particle_index;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_CLR_INIT,
      ST_IDLE,
      ST_L_TOT1,
      ST_L_TOT2,
      ST_L_AXX,
      ST_L_AXY,
      ST_L_AXZ,
      ST_L_ID1,
      ST_L_ID2,
      ST_L_ID3,
      ST_L_INC,
      ST_F1,
      ST_F1_END,
      ST_F2A,
      ST_F2B,
      ST_F2C,
      ST_Q2A,
      ST_Q2B,
      ST_Q3A,
      ST_Q3B,
      ST_CLR_OP,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/core/pcbs_ram.sv =====
// ----------------------------------------------------------------------------
// Particle cube binning sort RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pcbs_ram #(
   parameter int WIDTH  = 13,
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and read the array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pcbs_mul.sv =====
// ----------------------------------------------------------------------------
// Particle cube binning sort multiplier
// Shared 32 x 32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module pcbs_mul
   import pcbs_pkg::*;
(
   input  logic        clock,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [63:0] product
);

   logic [63:0] prod_ff;
   logic [63:0] prod_in;

   // form the product
   always_comb begin
      prod_in = 64'(op_a) * 64'(op_b);
   end

   // register it
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

// ===== rtl/core/particle_cube_binning_sort_unit.sv =====
// ----------------------------------------------------------------------------
// Particle cube binning sort unit
// Bins Q16.16 positions into a cube grid and counting-sorts them by cube id.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_data (opcode, pos, index)
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_data (status, ids, slots)
//  csr     | in        | csr_wr_en            | csr_index, csr_wr_data
//
// Loads are stepped by the sequencer through one shared multiplier; range and
// slot queries read RAMs with registered data; bad opcodes respond directly.
// Finalize runs a count pass over all cubes, then a slot pass over the loads.
// Clear and reset both run a count clearing pass over all cubes.
// A finished item waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
`include "particle_cube_binning_sort_unit_macros.svh"

module particle_cube_binning_sort_unit
   import pcbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wr_data
);

   localparam logic [CUBE_AW-1:0] CUBE_LAST = CUBE_AW'(MAX_CUBES - 1);

   // configuration
   logic [31:0] min_x_ff, min_y_ff, min_z_ff, inv_ff;
   logic [12:0] cubes_x_ff, cubes_y_ff, cubes_z_ff;

   // sequencer and datapath registers
   state_type state_ff, state_in;
   logic [32:0] dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [11:0] q_ff, q_in;
   logic        out_ff, out_in;
   logic [11:0] i_ff, i_in, j_ff, j_in, id_ff, id_in, pc_ff, pc_in;
   logic [12:0] run_ff, run_in;
   logic        pend_ff, pend_in;
   logic [11:0] pend_addr_ff, pend_addr_in;
   logic [12:0] cnt_ff, cnt_in;
   logic [12:0] lc_ff, lc_in;
   logic        fin_ff, fin_in;
   rsp_type     res_ff, res_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;

   // RAM ports
   logic        cnt_we, st_we, nx_we, pcu_we, sl_we;
   logic [11:0] cnt_wa, cnt_ra, st_wa, st_ra, nx_wa, nx_ra;
   logic [11:0] pcu_wa, pcu_ra, sl_wa, sl_ra;
   logic [12:0] cnt_wd, cnt_rd, st_wd, st_rd, nx_wd, nx_rd;
   logic [11:0] pcu_wd, pcu_rd, sl_wd, sl_rd;

   // helpers
   logic        accept, rsp_free, axis_out, clr_last;
   logic [12:0] t_sum;
   logic [11:0] id_w;

   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign axis_out = (prod[63:32] >= {19'd0, cubes_x_ff}) && (state_ff == ST_L_AXY)
                  || (prod[63:32] >= {19'd0, cubes_y_ff}) && (state_ff == ST_L_AXZ)
                  || (prod[63:32] >= {19'd0, cubes_z_ff}) && (state_ff == ST_L_ID1);
   assign clr_last = (cnt_ff[CUBE_AW-1:0] == CUBE_LAST);
   assign t_sum    = {1'b0, j_ff} + prod[12:0];
   assign id_w     = i_ff + prod[11:0];

   pcbs_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod)
   );

   pcbs_ram #(.WIDTH(13), .ADDR_W(CUBE_AW)) u_counts (
      .clock(clock), .wr_en(cnt_we), .wr_addr(cnt_wa), .wr_data(cnt_wd),
      .rd_addr(cnt_ra), .rd_data(cnt_rd)
   );

   pcbs_ram #(.WIDTH(13), .ADDR_W(CUBE_AW)) u_starts (
      .clock(clock), .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
      .rd_addr(st_ra), .rd_data(st_rd)
   );

   pcbs_ram #(.WIDTH(13), .ADDR_W(CUBE_AW)) u_next (
      .clock(clock), .wr_en(nx_we), .wr_addr(nx_wa), .wr_data(nx_wd),
      .rd_addr(nx_ra), .rd_data(nx_rd)
   );

   pcbs_ram #(.WIDTH(12), .ADDR_W(PART_AW)) u_pcubes (
      .clock(clock), .wr_en(pcu_we), .wr_addr(pcu_wa), .wr_data(pcu_wd),
      .rd_addr(pcu_ra), .rd_data(pcu_rd)
   );

   pcbs_ram #(.WIDTH(12), .ADDR_W(PART_AW)) u_slots (
      .clock(clock), .wr_en(sl_we), .wr_addr(sl_wa), .wr_data(sl_wd),
      .rd_addr(sl_ra), .rd_data(sl_rd)
   );

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff   <= 32'd0;
         min_y_ff   <= 32'd0;
         min_z_ff   <= 32'd0;
         inv_ff     <= 32'd65536;
         cubes_x_ff <= 13'd16;
         cubes_y_ff <= 13'd16;
         cubes_z_ff <= 13'd16;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MIN_X:   min_x_ff   <= csr_wr_data;
            CSR_MIN_Y:   min_y_ff   <= csr_wr_data;
            CSR_MIN_Z:   min_z_ff   <= csr_wr_data;
            CSR_INV:     inv_ff     <= csr_wr_data;
            CSR_CUBES_X: cubes_x_ff <= csr_wr_data[12:0];
            CSR_CUBES_Y: cubes_y_ff <= csr_wr_data[12:0];
            CSR_CUBES_Z: cubes_z_ff <= csr_wr_data[12:0];
            default: ;
         endcase
      end
   end

   // pick the next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLR_INIT: if (clr_last) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               case (req_data.opcode)
                  OP_LOAD:     state_in = ST_L_TOT1;
                  OP_FINALIZE: state_in = ST_F1;
                  OP_RANGE:    state_in = ST_Q2A;
                  OP_SLOT:     state_in = ST_Q3A;
                  OP_CLEAR:    state_in = ST_CLR_OP;
                  default:     state_in = ST_DONE;
               endcase
            end
         end
         ST_L_TOT1: state_in = ST_L_TOT2;
         ST_L_TOT2: state_in = ST_L_AXX;
         ST_L_AXX:  state_in = (prod > 64'(MAX_CUBES)) ? ST_DONE : ST_L_AXY;
         ST_L_AXY:  state_in = ST_L_AXZ;
         ST_L_AXZ:  state_in = ST_L_ID1;
         ST_L_ID1:  state_in = (out_ff || axis_out || dz_ff[32]) ? ST_DONE : ST_L_ID2;
         ST_L_ID2:  state_in = ST_L_ID3;
         ST_L_ID3:  state_in = (lc_ff == 13'(MAX_PARTICLES)) ? ST_DONE : ST_L_INC;
         ST_L_INC:  state_in = ST_DONE;
         ST_F1:     if (clr_last) state_in = ST_F1_END;
         ST_F1_END: state_in = ST_F2A;
         ST_F2A:    state_in = (cnt_ff == lc_ff) ? ST_DONE : ST_F2B;
         ST_F2B:    state_in = ST_F2C;
         ST_F2C:    state_in = ST_F2A;
         ST_Q2A:    state_in = fin_ff ? ST_Q2B : ST_DONE;
         ST_Q2B:    state_in = ST_DONE;
         ST_Q3A:    state_in = (fin_ff && ({1'b0, q_ff} < lc_ff)) ? ST_Q3B : ST_DONE;
         ST_Q3B:    state_in = ST_DONE;
         ST_CLR_OP: if (clr_last) state_in = ST_DONE;
         ST_DONE:   if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // drive datapath, RAM ports and outputs
   always_comb begin
      dx_in = dx_ff; dy_in = dy_ff; dz_in = dz_ff; q_in = q_ff;
      out_in = out_ff; i_in = i_ff; j_in = j_ff; id_in = id_ff; pc_in = pc_ff;
      run_in = run_ff; pend_in = 1'b0; pend_addr_in = cnt_ff[CUBE_AW-1:0];
      cnt_in = cnt_ff; lc_in = lc_ff; fin_in = fin_ff; res_in = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mul_a = 32'd0; mul_b = 32'd0;
      cnt_we = 1'b0; cnt_wa = '0; cnt_wd = '0; cnt_ra = '0;
      st_we = 1'b0; st_wa = pend_addr_ff; st_wd = run_ff; st_ra = q_ff;
      nx_we = 1'b0; nx_wa = pend_addr_ff; nx_wd = run_ff; nx_ra = pcu_rd;
      pcu_we = 1'b0; pcu_wa = lc_ff[PART_AW-1:0]; pcu_wd = id_w; pcu_ra = q_ff;
      sl_we = 1'b0; sl_wa = cnt_ff[PART_AW-1:0]; sl_wd = nx_rd[11:0]; sl_ra = q_ff;

      // store prefix sums in the cycle after the count read
      if (pend_ff) begin
         st_we  = 1'b1;
         nx_we  = 1'b1;
         run_in = run_ff + cnt_rd;
      end

      case (state_ff)
         ST_CLR_INIT, ST_CLR_OP: begin
            cnt_we = 1'b1;
            cnt_wa = cnt_ff[CUBE_AW-1:0];
            cnt_in = cnt_ff + 13'd1;
            if (state_ff == ST_CLR_OP) begin
               lc_in  = '0;
               fin_in = 1'b0;
            end
         end
         ST_IDLE: begin
            dx_in  = {req_data.pos_x[31], req_data.pos_x} - {min_x_ff[31], min_x_ff};
            dy_in  = {req_data.pos_y[31], req_data.pos_y} - {min_y_ff[31], min_y_ff};
            dz_in  = {req_data.pos_z[31], req_data.pos_z} - {min_z_ff[31], min_z_ff};
            q_in   = req_data.query_index;
            out_in = 1'b0;
            run_in = '0;
            cnt_in = '0;
            res_in = '0;
            if (req_data.opcode > OP_CLEAR) res_in.status = STAT_BAD;
         end
         ST_L_TOT1: begin
            mul_a = {19'd0, cubes_x_ff};
            mul_b = {19'd0, cubes_y_ff};
         end
         ST_L_TOT2: begin
            mul_a = prod[31:0];
            mul_b = {19'd0, cubes_z_ff};
         end
         ST_L_AXX: begin
            if (prod > 64'(MAX_CUBES)) res_in.status = STAT_BAD;
            mul_a = dx_ff[31:0];
            mul_b = inv_ff;
         end
         ST_L_AXY: begin
            out_in = out_ff || axis_out || dx_ff[32];
            i_in   = prod[43:32];
            mul_a  = dy_ff[31:0];
            mul_b  = inv_ff;
         end
         ST_L_AXZ: begin
            out_in = out_ff || axis_out || dy_ff[32];
            j_in   = prod[43:32];
            mul_a  = dz_ff[31:0];
            mul_b  = inv_ff;
         end
         ST_L_ID1: begin
            if (out_ff || axis_out || dz_ff[32]) res_in.status = STAT_OUTSIDE;
            mul_a = {19'd0, cubes_y_ff};
            mul_b = {20'd0, prod[43:32]};
         end
         ST_L_ID2: begin
            mul_a = {19'd0, cubes_x_ff};
            mul_b = {19'd0, t_sum};
         end
         ST_L_ID3: begin
            if (lc_ff == 13'(MAX_PARTICLES)) begin
               res_in.status = STAT_FULL;
            end else begin
               pcu_we = 1'b1;
               cnt_ra = id_w;
               id_in  = id_w;
               res_in.cube_id        = id_w;
               res_in.particle_index = lc_ff[11:0];
            end
         end
         ST_L_INC: begin
            cnt_we = 1'b1;
            cnt_wa = id_ff;
            cnt_wd = cnt_rd + 13'd1;
            lc_in  = lc_ff + 13'd1;
            fin_in = 1'b0;
         end
         ST_F1: begin
            cnt_ra  = cnt_ff[CUBE_AW-1:0];
            pend_in = 1'b1;
            cnt_in  = clr_last ? 13'd0 : cnt_ff + 13'd1;
         end
         ST_F1_END: cnt_in = '0;
         ST_F2A: begin
            pcu_ra = cnt_ff[PART_AW-1:0];
            if (cnt_ff == lc_ff) fin_in = 1'b1;
         end
         ST_F2B: pc_in = pcu_rd;
         ST_F2C: begin
            sl_we  = 1'b1;
            nx_we  = 1'b1;
            nx_wa  = pc_ff;
            nx_wd  = nx_rd + 13'd1;
            cnt_in = cnt_ff + 13'd1;
         end
         ST_Q2A: begin
            cnt_ra = q_ff;
            if (!fin_ff) res_in.status = STAT_NOTFIN;
         end
         ST_Q2B: begin
            res_in.cube_id     = q_ff;
            res_in.range_first = st_rd;
            res_in.range_last  = st_rd + cnt_rd;
         end
         ST_Q3A: begin
            if (!fin_ff) res_in.status = STAT_NOTFIN;
            else if ({1'b0, q_ff} >= lc_ff) res_in.status = STAT_BAD;
         end
         ST_Q3B: begin
            res_in.cube_id        = pcu_rd;
            res_in.sorted_slot    = sl_rd;
            res_in.particle_index = q_ff;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: ;
      endcase
   end

   // advance control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR_INIT;
         cnt_ff       <= '0;
         lc_ff        <= '0;
         fin_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         lc_ff        <= lc_in;
         fin_ff       <= fin_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // advance payload registers
   always_ff @(posedge clock) begin
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      dz_ff        <= dz_in;
      q_ff         <= q_in;
      out_ff       <= out_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      id_ff        <= id_in;
      pc_ff        <= pc_in;
      run_ff       <= run_in;
      pend_addr_ff <= pend_addr_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // check sequencer bookkeeping
   `PCBS_ASSERT_NEXT(a_done_emits, (state_ff == ST_DONE) && rsp_free, rsp_valid_ff, "done item not emitted")
   `PCBS_ASSERT_NEXT(a_load_counts, state_ff == ST_L_INC, lc_ff == $past(lc_ff) + 13'd1, "load count not advanced")
   `PCBS_ASSERT_NEXT(a_fin_sets, (state_ff == ST_F2A) && (cnt_ff == lc_ff), fin_ff, "finalize flag not set")
   `PCBS_ASSERT_SAME(a_query_fin, (state_ff == ST_Q2B) || (state_ff == ST_Q3B), fin_ff, "query read before finalize")

endmodule

// ===== tb/particle_cube_binning_sort_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Particle cube binning sort unit testbench
// Drives loads, finalizes, range and slot queries and clears into the unit,
// predicts every response from a local model of the binning sort and checks
// each response field by field, with random idling on both channels outside phase A.
// ----------------------------------------------------------------------------
module particle_cube_binning_sort_unit_tb;
   import pcbs_pkg::*;

   localparam int PERIOD_HI   = 6;
   localparam int PERIOD_LO   = 6;
   localparam int WATCH_LIMIT = 200000;
   localparam int RAND_ITEMS  = 1700;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [31:0] csr_wr_data;

   particle_cube_binning_sort_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // shadow of the unit's registers and store
   logic signed [31:0] grid_min_x, grid_min_y, grid_min_z;
   logic [31:0]        grid_inv;
   logic [12:0]        grid_nx, grid_ny, grid_nz;
   logic [12:0]        bin_count [MAX_CUBES];
   logic [12:0]        bin_start [MAX_CUBES];
   logic [11:0]        part_cube [MAX_PARTICLES];
   logic [11:0]        part_slot [MAX_PARTICLES];
   int                 num_loaded;
   bit                 is_sorted;

   rsp_type pending_rsp [$];
   int      fail_count;
   int      rsp_seen;
   int      idle_cycles;
   bit      quiet_mode;

   // directed rows: request plus an optional typed-in response
   typedef struct {
      req_type req;
      bit      fixed;
      rsp_type rsp;
   } row_type;

   always begin
      clock = 1'b1;
      #PERIOD_HI;
      clock = 1'b0;
      #PERIOD_LO;
   end

   function automatic bit axis_bin(logic signed [31:0] pos, logic signed [31:0] lo,
                                   logic [12:0] n, output logic [63:0] idx);
      logic signed [33:0] d;
      logic [63:0]        prod;
      d = 34'(pos) - 34'(lo);
      idx = '0;
      if (d < 0) return 1'b0;
      prod = 64'(d[32:0]) * 64'(grid_inv);
      idx = prod >> 32;
      return idx < 64'(n);
   endfunction

   // compute the response of one item and update the shadow store
   function automatic rsp_type bin_sort_predict(req_type r);
      rsp_type     o;
      logic [63:0] ix, iy, iz, total, id;
      int          run;
      int          next_free [MAX_CUBES];
      o = '0;
      o.status = STAT_OK;
      case (r.opcode)
         OP_LOAD: begin
            total = 64'(grid_nx) * 64'(grid_ny) * 64'(grid_nz);
            if (total > 64'(MAX_CUBES)) begin
               o.status = STAT_BAD;
            end else if (!axis_bin(r.pos_x, grid_min_x, grid_nx, ix) ||
                         !axis_bin(r.pos_y, grid_min_y, grid_ny, iy) ||
                         !axis_bin(r.pos_z, grid_min_z, grid_nz, iz)) begin
               o.status = STAT_OUTSIDE;
            end else if (num_loaded >= MAX_PARTICLES) begin
               o.status = STAT_FULL;
            end else begin
               id = ix + 64'(grid_nx) * (iy + 64'(grid_ny) * iz);
               part_cube[num_loaded] = id[11:0];
               bin_count[id[11:0]] = bin_count[id[11:0]] + 13'd1;
               o.cube_id = id[11:0];
               o.particle_index = 12'(num_loaded);
               num_loaded++;
               is_sorted = 1'b0;
            end
         end
         OP_FINALIZE: begin
            run = 0;
            for (int c = 0; c < MAX_CUBES; c++) begin
               bin_start[c] = 13'(run);
               next_free[c] = run;
               run += bin_count[c];
            end
            for (int p = 0; p < num_loaded; p++) begin
               part_slot[p] = 12'(next_free[part_cube[p]]);
               next_free[part_cube[p]]++;
            end
            is_sorted = 1'b1;
         end
         OP_RANGE: begin
            if (!is_sorted) begin
               o.status = STAT_NOTFIN;
            end else begin
               o.cube_id = r.query_index;
               o.range_first = bin_start[r.query_index];
               o.range_last = bin_start[r.query_index] + bin_count[r.query_index];
            end
         end
         OP_SLOT: begin
            if (!is_sorted) begin
               o.status = STAT_NOTFIN;
            end else if (int'(r.query_index) >= num_loaded) begin
               o.status = STAT_BAD;
            end else begin
               o.cube_id = part_cube[r.query_index];
               o.sorted_slot = part_slot[r.query_index];
               o.particle_index = r.query_index;
            end
         end
         OP_CLEAR: begin
            foreach (bin_count[c]) bin_count[c] = '0;
            num_loaded = 0;
            is_sorted = 1'b0;
         end
         default: o.status = STAT_BAD;
      endcase
      return o;
   endfunction

   // random stall on the response side, with a quiet stretch
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= quiet_mode ? 1'b0 : ($urandom_range(99) < 17);
   end

   // compare every accepted response with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_data);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status ||
                rsp_data.cube_id !== want.cube_id ||
                rsp_data.range_first !== want.range_first ||
                rsp_data.range_last !== want.range_last ||
                rsp_data.sorted_slot !== want.sorted_slot ||
                rsp_data.particle_index !== want.particle_index) begin
               $display("%0t: mismatch expected st=%0d cid=%0d rf=%0d rl=%0d slot=%0d pi=%0d",
                        $time, want.status, want.cube_id, want.range_first,
                        want.range_last, want.sorted_slot, want.particle_index);
               $display("%0t:          actual   st=%0d cid=%0d rf=%0d rl=%0d slot=%0d pi=%0d",
                        $time, rsp_data.status, rsp_data.cube_id, rsp_data.range_first,
                        rsp_data.range_last, rsp_data.sorted_slot, rsp_data.particle_index);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no accepted item
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("particle_cube_binning_sort_unit_tb NOT OK");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      case (idx)
         CSR_MIN_X:   grid_min_x = val;
         CSR_MIN_Y:   grid_min_y = val;
         CSR_MIN_Z:   grid_min_z = val;
         CSR_INV:     grid_inv = val;
         CSR_CUBES_X: grid_nx = val[12:0];
         CSR_CUBES_Y: grid_ny = val[12:0];
         CSR_CUBES_Z: grid_nz = val[12:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // wait for all responses to drain before touching the registers
   task automatic drain_wait();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // offer one item, hold it until taken, queue its prediction
   task automatic send_item(req_type r, bit fixed, rsp_type fixed_rsp);
      rsp_type p;
      while (!quiet_mode && $urandom_range(99) < 17) begin
         @(posedge clock);
         req_valid <= 1'b0;
      end
      @(posedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      req_valid <= 1'b0;
      p = bin_sort_predict(r);
      if (fixed && p !== fixed_rsp) begin
         $display("%0t: table row expected %h, model gives %h", $time, fixed_rsp, p);
         fail_count++;
      end
      pending_rsp = {pending_rsp, p};
   endtask

   function automatic req_type make_req(logic [2:0] op, logic [31:0] x, logic [31:0] y,
                                        logic [31:0] z, logic [11:0] q);
      req_type r;
      r.opcode = op;
      r.pos_x = x;
      r.pos_y = y;
      r.pos_z = z;
      r.query_index = q;
      return r;
   endfunction

   function automatic rsp_type make_rsp(logic [2:0] st, logic [11:0] cid, logic [12:0] rf,
                                        logic [12:0] rl, logic [11:0] sl, logic [11:0] pi);
      rsp_type o;
      o.status = st;
      o.cube_id = cid;
      o.range_first = rf;
      o.range_last = rl;
      o.sorted_slot = sl;
      o.particle_index = pi;
      return o;
   endfunction

   // coordinate inside the current grid along one axis, or a noisy one
   function automatic logic [31:0] rand_coord(logic signed [31:0] lo, logic [12:0] n);
      logic [63:0] span;
      if ($urandom_range(9) == 0) return $urandom();
      if (grid_inv == 0) return lo + $urandom_range(1000);
      span = (64'(n) << 32) / 64'(grid_inv);
      if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
      return lo + 32'($urandom_range(32'(span)));
   endfunction

   task automatic random_phase(int count, int qmax);
      req_type r;
      int      pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 60)
            r = make_req(OP_LOAD, rand_coord(grid_min_x, grid_nx),
                         rand_coord(grid_min_y, grid_ny), rand_coord(grid_min_z, grid_nz),
                         $urandom());
         else if (pick < 64)
            r = make_req(OP_FINALIZE, $urandom(), $urandom(), $urandom(), $urandom());
         else if (pick < 80)
            r = make_req(OP_RANGE, $urandom(), $urandom(), $urandom(),
                         $urandom_range(qmax));
         else if (pick < 96)
            r = make_req(OP_SLOT, $urandom(), $urandom(), $urandom(),
                         $urandom_range(num_loaded + 2));
         else if (pick < 98)
            r = make_req(OP_CLEAR, $urandom(), $urandom(), $urandom(), $urandom());
         else
            r = make_req(3'($urandom_range(7, 5)), $urandom(), $urandom(), $urandom(),
                         $urandom());
         send_item(r, 1'b0, '0);
      end
      send_item(make_req(OP_FINALIZE, 0, 0, 0, 0), 1'b0, '0);
      repeat (40) send_item(make_req(OP_SLOT, $urandom(), $urandom(), $urandom(),
                                     $urandom_range(num_loaded)), 1'b0, '0);
   endtask

   row_type dir_rows [$];

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_MIN_X;
      csr_wr_data = '0;
      fail_count = 0;
      rsp_seen = 0;
      idle_cycles = 0;
      quiet_mode = 1'b0;
      grid_min_x = 0; grid_min_y = 0; grid_min_z = 0;
      grid_inv = 32'd65536;
      grid_nx = 13'd16; grid_ny = 13'd16; grid_nz = 13'd16;
      foreach (bin_count[c]) begin
         bin_count[c] = '0;
         bin_start[c] = '0;
      end
      foreach (part_cube[p]) begin
         part_cube[p] = '0;
         part_slot[p] = '0;
      end
      num_loaded = 0;
      is_sorted = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table: reset state, extremes, every op and the error codes other than full
      dir_rows = '{
         '{make_req(OP_RANGE, 0, 0, 0, 0), 1, make_rsp(STAT_NOTFIN, 0, 0, 0, 0, 0)},
         '{make_req(OP_SLOT, 0, 0, 0, 12'hFFF), 1, make_rsp(STAT_NOTFIN, 0, 0, 0, 0, 0)},
         '{make_req(OP_LOAD, 0, 0, 0, 0), 1, make_rsp(STAT_OK, 0, 0, 0, 0, 0)},
         '{make_req(OP_LOAD, 32'h000F_FFFF, 32'h000F_FFFF, 32'h000F_FFFF, 0), 1,
           make_rsp(STAT_OK, 12'hFFF, 0, 0, 0, 1)},
         '{make_req(OP_LOAD, 32'h0010_0000, 0, 0, 0), 1,
           make_rsp(STAT_OUTSIDE, 0, 0, 0, 0, 0)},
         '{make_req(OP_LOAD, 32'hFFFF_FFFF, 0, 0, 0), 1,
           make_rsp(STAT_OUTSIDE, 0, 0, 0, 0, 0)},
         '{make_req(OP_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0), 1,
           make_rsp(STAT_OUTSIDE, 0, 0, 0, 0, 0)},
         '{make_req(OP_LOAD, 32'h0003_8000, 32'h0001_0000, 32'h0002_0000, 0), 0, '0},
         '{make_req(OP_LOAD, 0, 0, 0, 0), 0, '0},
         '{make_req(OP_FINALIZE, 0, 0, 0, 0), 1, make_rsp(STAT_OK, 0, 0, 0, 0, 0)},
         '{make_req(OP_RANGE, 0, 0, 0, 0), 0, '0},
         '{make_req(OP_RANGE, 0, 0, 0, 12'hFFF), 0, '0},
         '{make_req(OP_SLOT, 0, 0, 0, 1), 0, '0},
         '{make_req(OP_SLOT, 0, 0, 0, 3), 0, '0},
         '{make_req(OP_SLOT, 0, 0, 0, 4), 1, make_rsp(STAT_BAD, 0, 0, 0, 0, 0)},
         '{make_req(OP_SLOT, 0, 0, 0, 12'hFFF), 1, make_rsp(STAT_BAD, 0, 0, 0, 0, 0)},
         '{make_req(OP_LOAD, 32'h0001_0000, 0, 0, 0), 0, '0},
         '{make_req(OP_RANGE, 0, 0, 0, 1), 1, make_rsp(STAT_NOTFIN, 0, 0, 0, 0, 0)},
         '{make_req(OP_FINALIZE, 0, 0, 0, 0), 0, '0},
         '{make_req(OP_FINALIZE, 0, 0, 0, 0), 0, '0},
         '{make_req(OP_SLOT, 0, 0, 0, 4), 0, '0},
         '{make_req(3'd5, 0, 0, 0, 0), 1, make_rsp(STAT_BAD, 0, 0, 0, 0, 0)},
         '{make_req(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF), 1,
           make_rsp(STAT_BAD, 0, 0, 0, 0, 0)},
         '{make_req(OP_CLEAR, 0, 0, 0, 0), 1, make_rsp(STAT_OK, 0, 0, 0, 0, 0)},
         '{make_req(OP_SLOT, 0, 0, 0, 0), 1, make_rsp(STAT_NOTFIN, 0, 0, 0, 0, 0)}
      };
      foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].rsp);

      // grid too large, then an empty grid
      drain_wait();
      csr_write(CSR_CUBES_X, 32'd4096);
      csr_write(CSR_CUBES_Y, 32'd2);
      send_item(make_req(OP_LOAD, 0, 0, 0, 0), 1'b1, make_rsp(STAT_BAD, 0, 0, 0, 0, 0));
      drain_wait();
      csr_write(CSR_CUBES_Y, 32'd0);
      csr_write(CSR_CUBES_X, 32'd16);
      send_item(make_req(OP_LOAD, 0, 0, 0, 0), 1'b1,
                make_rsp(STAT_OUTSIDE, 0, 0, 0, 0, 0));

      // phase A: reset grid with a partly random domain corner, no stalls
      drain_wait();
      quiet_mode = 1'b1;
      csr_write(CSR_CUBES_Y, 32'd16);
      csr_write(CSR_MIN_X, 32'hFFF0_0000);
      csr_write(CSR_MIN_Y, $urandom());
      csr_write(CSR_MIN_Z, 32'h8000_0000);
      random_phase(300, MAX_CUBES - 1);
      quiet_mode = 1'b0;

      // phase B: long line of cubes, fine cube size
      drain_wait();
      csr_write(CSR_CUBES_X, 32'd4096);
      csr_write(CSR_CUBES_Y, 32'd1);
      csr_write(CSR_CUBES_Z, 32'd1);
      csr_write(CSR_INV, 32'hFFFF_FFFF);
      csr_write(CSR_MIN_X, 32'h7FFF_0000);
      csr_write(CSR_MIN_Y, 32'h7FFF_FFFF);
      csr_write(CSR_MIN_Z, 32'h0);
      random_phase(400, MAX_CUBES - 1);

      // phase C: tiny grid, coarse cubes, inverse zero then small
      drain_wait();
      csr_write(CSR_CUBES_X, 32'd1);
      csr_write(CSR_CUBES_Y, 32'd2);
      csr_write(CSR_CUBES_Z, 32'd3);
      csr_write(CSR_INV, 32'd0);
      csr_write(CSR_MIN_X, 32'h8000_0000);
      csr_write(CSR_MIN_Y, 32'h8000_0000);
      csr_write(CSR_MIN_Z, 32'hFFFF_0000);
      random_phase(150, 16);
      drain_wait();
      csr_write(CSR_INV, 32'd1);
      random_phase(200, 16);

      // phase D: mixed grid with random corners, rest of the item budget
      drain_wait();
      csr_write(CSR_CUBES_X, 32'd8);
      csr_write(CSR_CUBES_Y, 32'd32);
      csr_write(CSR_CUBES_Z, 32'd16);
      csr_write(CSR_INV, 32'h0002_0000 + $urandom_range(65535));
      csr_write(CSR_MIN_X, $urandom());
      csr_write(CSR_MIN_Y, $urandom());
      csr_write(CSR_MIN_Z, $urandom());
      random_phase(RAND_ITEMS - 1282, MAX_CUBES - 1);

      // finish: drain and linger
      drain_wait();
      repeat (50) @(posedge clock);
      $display("covered loads, sorts, range and slot queries, clears and bad opcodes");
      $display("over five grid settings; %0d responses checked", rsp_seen);
      if (fail_count == 0 && pending_rsp.size() == 0) begin
         $display("particle_cube_binning_sort_unit_tb OK");
      end else begin
         $display("particle_cube_binning_sort_unit_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== particle_cube_binning_sort_unit.f =====
+incdir+rtl/core
rtl/core/pcbs_pkg.sv
rtl/core/pcbs_ram.sv
rtl/core/pcbs_mul.sv
rtl/core/particle_cube_binning_sort_unit.sv
tb/particle_cube_binning_sort_unit_tb.sv
